@@ design/sems_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sems_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WIN_DEPTH = 32;
    localparam int RING_DEPTH = 16;

    localparam logic [2:0] REG_WINDOW = 3'd0;
    localparam logic [2:0] REG_EVENTS = 3'd1;
    localparam logic [2:0] REG_QUANT = 3'd2;
    localparam logic [2:0] REG_KMER = 3'd3;
    localparam logic [2:0] REG_THRESH = 3'd4;
    localparam logic [2:0] REG_FMIN = 3'd5;
    localparam logic [2:0] REG_FMAX = 3'd6;
    localparam logic [2:0] REG_FSHARE = 3'd7;

    localparam logic [4:0] OP_NONE = 5'd0;
    localparam logic [4:0] OP_LOAD = 5'd1;
    localparam logic [4:0] OP_KEEP = 5'd2;
    localparam logic [4:0] OP_MUL2 = 5'd3;
    localparam logic [4:0] OP_DIV0 = 5'd4;
    localparam logic [4:0] OP_DIV = 5'd5;
    localparam logic [4:0] OP_UPD = 5'd6;
    localparam logic [4:0] OP_H1 = 5'd7;
    localparam logic [4:0] OP_H2 = 5'd8;
    localparam logic [4:0] OP_EMIT_ENT = 5'd9;
    localparam logic [4:0] OP_WIN = 5'd10;
    localparam logic [4:0] OP_TWIN = 5'd11;
    localparam logic [4:0] OP_EMIT_MIN = 5'd12;
    localparam logic [4:0] OP_SETMIN = 5'd13;
    localparam logic [4:0] OP_RSINIT = 5'd14;
    localparam logic [4:0] OP_RSCAN = 5'd15;
    localparam logic [4:0] OP_SCAN0 = 5'd16;
    localparam logic [4:0] OP_WEND = 5'd17;
    localparam logic [4:0] OP_CLEAR = 5'd18;
    localparam logic [4:0] OP_FINAL = 5'd19;

    typedef struct packed {
        logic [4:0] op;
        logic       full;
    } sems_cmd_t;

    typedef struct packed {
        logic keep;
        logic ring_full;
        logic plain;
        logic cond_a;
        logic w_one;
        logic less_eq;
        logic same_slot;
        logic ge_e;
        logic ge_e1;
        logic min_valid;
        logic room;
        logic adv;
        logic scan_last;
        logic div_done;
        logic flush;
        logic last_item;
        logic pend_v;
        logic fin_ok;
    } sems_stat_t;

    function automatic logic [31:0] mix_lo(input logic [31:0] k);
        logic [31:0] k1;
        logic [31:0] k2;
        k1 = ~k + (k << 21);
        k2 = k1 ^ (k1 >> 24);
        return k2 + (k2 << 3) + (k2 << 8);
    endfunction

    function automatic logic [31:0] mix_hi(input logic [31:0] k);
        logic [31:0] k4;
        logic [31:0] k5;
        logic [31:0] k6;
        k4 = k ^ (k >> 14);
        k5 = k4 + (k4 << 2) + (k4 << 4);
        k6 = k5 ^ (k5 >> 28);
        return k6 + (k6 << 31);
    endfunction

endpackage

`default_nettype wire

@@ design/sems_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sems_in_if;
    import sems_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [31:0]                read_id;
    logic                       strand;
    logic                       first_of_read;
    logic                       last_of_read;

    modport source (output valid, sample, read_id, strand, first_of_read, last_of_read,
                    input ready);
    modport sink (input valid, sample, read_id, strand, first_of_read, last_of_read,
                  output ready);
endinterface

`default_nettype wire

@@ design/sems_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sems_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic [31:0] event_position;
    logic [31:0] read_tag;
    logic        strand_out;
    logic [6:0]  span;
    logic        last_of_run;

    modport source (output valid, hash_value, event_position, read_tag, strand_out, span,
                    last_of_run, input ready);
    modport sink (input valid, hash_value, event_position, read_tag, strand_out, span,
                  last_of_run, output ready);
endinterface

`default_nettype wire

@@ design/sems_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sems_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output sems_pkg::sems_cmd_t       cmd,
    input  wire sems_pkg::sems_stat_t stat
);
    import sems_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_KEEP = 5'd1;
    localparam logic [4:0] S_MUL2 = 5'd2;
    localparam logic [4:0] S_DIV0 = 5'd3;
    localparam logic [4:0] S_DIV = 5'd4;
    localparam logic [4:0] S_UPD = 5'd5;
    localparam logic [4:0] S_H1 = 5'd6;
    localparam logic [4:0] S_H2 = 5'd7;
    localparam logic [4:0] S_PLAIN = 5'd8;
    localparam logic [4:0] S_WIN = 5'd9;
    localparam logic [4:0] S_TWA = 5'd10;
    localparam logic [4:0] S_BSEL = 5'd11;
    localparam logic [4:0] S_EML = 5'd12;
    localparam logic [4:0] S_SETMIN = 5'd13;
    localparam logic [4:0] S_EMQ = 5'd14;
    localparam logic [4:0] S_RSI = 5'd15;
    localparam logic [4:0] S_RS = 5'd16;
    localparam logic [4:0] S_RSX = 5'd17;
    localparam logic [4:0] S_TWB = 5'd18;
    localparam logic [4:0] S_WEND = 5'd19;
    localparam logic [4:0] S_TAIL = 5'd20;
    localparam logic [4:0] S_CLR = 5'd21;
    localparam logic [4:0] S_FIN = 5'd22;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        cmd.full = 1'b0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_KEEP;
                end
            end
            S_KEEP:
            begin
                cmd.op = OP_KEEP;
                state_next = stat.keep ? S_MUL2 : S_TAIL;
            end
            S_MUL2:
            begin
                cmd.op = OP_MUL2;
                state_next = S_DIV0;
            end
            S_DIV0:
            begin
                cmd.op = OP_DIV0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (stat.div_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op = OP_UPD;
                state_next = S_H1;
            end
            S_H1:
            begin
                cmd.op = OP_H1;
                state_next = S_H2;
            end
            S_H2:
            begin
                cmd.op = OP_H2;
                if (!stat.ring_full)
                    state_next = S_TAIL;
                else if (stat.plain)
                    state_next = S_PLAIN;
                else
                    state_next = S_WIN;
            end
            S_PLAIN:
            begin
                cmd.op = OP_EMIT_ENT;
                if (stat.room)
                    state_next = S_TAIL;
            end
            S_WIN:
            begin
                cmd.op = OP_WIN;
                state_next = (stat.cond_a && !stat.w_one) ? S_TWA : S_BSEL;
            end
            S_TWA:
            begin
                cmd.op = OP_TWIN;
                if (stat.adv && stat.scan_last)
                    state_next = S_BSEL;
            end
            S_BSEL:
            begin
                priority if (stat.less_eq)
                    state_next = (stat.ge_e && stat.min_valid) ? S_EML : S_SETMIN;
                else if (stat.same_slot)
                    state_next = (stat.ge_e1 && stat.min_valid) ? S_EMQ : S_RSI;
                else
                    state_next = S_WEND;
            end
            S_EML:
            begin
                cmd.op = OP_EMIT_MIN;
                if (stat.room)
                    state_next = S_SETMIN;
            end
            S_SETMIN:
            begin
                cmd.op = OP_SETMIN;
                state_next = S_WEND;
            end
            S_EMQ:
            begin
                cmd.op = OP_EMIT_MIN;
                if (stat.room)
                    state_next = S_RSI;
            end
            S_RSI:
            begin
                cmd.op = OP_RSINIT;
                state_next = S_RS;
            end
            S_RS:
            begin
                cmd.op = OP_RSCAN;
                cmd.full = 1'b1;
                if (stat.scan_last)
                    state_next = S_RSX;
            end
            S_RSX:
            begin
                cmd.op = OP_SCAN0;
                state_next = (stat.ge_e1 && stat.min_valid) ? S_TWB : S_WEND;
            end
            S_TWB:
            begin
                cmd.op = OP_TWIN;
                cmd.full = 1'b1;
                if (stat.adv && stat.scan_last)
                    state_next = S_WEND;
            end
            S_WEND:
            begin
                cmd.op = OP_WEND;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                priority if (stat.flush)
                begin
                    cmd.op = OP_EMIT_MIN;
                    if (stat.room)
                        state_next = S_CLR;
                end
                else if (stat.last_item)
                    state_next = S_CLR;
                else
                    state_next = S_FIN;
            end
            S_CLR:
            begin
                cmd.op = OP_CLEAR;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = OP_FINAL;
                if (stat.fin_ok)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !stat.pend_v)
        else $error("pending result left over at idle");

    a_plain_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLAIN) |-> stat.plain)
        else $error("plain emit outside plain mode");

    a_div_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV0) |=> (state_reg == S_DIV))
        else $error("divider start not followed by steps");

endmodule

`default_nettype wire

@@ design/sems_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sems_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       write_en,
    input  wire logic [2:0]                 write_index,
    input  wire logic [15:0]                write_data,
    input  wire logic signed [sems_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [31:0]                read_id,
    input  wire logic                       strand,
    input  wire logic                       first_of_read,
    input  wire logic                       last_of_read,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [31:0]                     hash_value,
    output logic [31:0]                     event_position,
    output logic [31:0]                     read_tag,
    output logic                            strand_out,
    output logic [6:0]                      span,
    output logic                            last_of_run,
    input  wire sems_pkg::sems_cmd_t        cmd,
    output sems_pkg::sems_stat_t            stat
);
    import sems_pkg::*;

    // Configuration.
    logic [5:0]         ws_reg;
    logic [4:0]         ec_reg;
    logic [3:0]         qb_reg;
    logic [6:0]         kl_reg;
    logic [15:0]        thr_reg;
    logic signed [15:0] fmin_reg;
    logic signed [15:0] fmax_reg;
    logic [15:0]        fsh_reg;

    // Current item.
    logic signed [15:0] smp_reg;
    logic [31:0]        tag_reg;
    logic               str_reg;
    logic               last_reg;

    // Read state.
    logic signed [15:0] lks_reg;
    logic [31:0]        sidx_reg;
    logic [31:0]        etot_reg;
    logic [63:0]        hist_reg;
    logic [31:0]        ring_reg [RING_DEPTH];
    logic [3:0]         ri_reg;
    logic               rfull_reg;
    logic [63:0]        win_reg [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] wv_reg;
    logic [4:0]         widx_reg;
    logic [63:0]        cmin_reg;
    logic               mval_reg;
    logic [4:0]         mslot_reg;

    // Work registers.
    logic               inb_reg;
    logic               neg_reg;
    logic               degen_reg;
    logic signed [34:0] p_reg;
    logic signed [44:0] num_reg;
    logic [31:0]        den_reg;
    logic [43:0]        rem_reg;
    logic [43:0]        dsh_reg;
    logic [7:0]         quot_reg;
    logic [2:0]         dcnt_reg;
    logic               zero_reg;
    logic               sat_reg;
    logic [31:0]        h1_reg;
    logic [63:0]        ent_reg;
    logic [4:0]         bp_reg;
    logic [4:0]         mp_reg;
    logic [32:0]        mkey_reg;
    logic [5:0]         cnt_reg;

    // Result buffering.
    logic               pend_v_reg;
    logic [63:0]        pend_reg;
    logic               out_v_reg;
    logic [63:0]        out_ent_reg;
    logic [31:0]        out_tag_reg;
    logic               out_str_reg;
    logic [6:0]         out_span_reg;
    logic               out_last_reg;

    logic [5:0]         w_eff;
    logic [4:0]         e_eff;
    logic [3:0]         q_eff;
    logic [7:0]         mx;
    logic [6:0]         span_v;
    logic signed [16:0] dlt;
    logic [16:0]        adlt;
    logic               keep_v;
    logic               inb_v;
    logic [16:0]        fac_a;
    logic signed [16:0] fac_b;
    logic signed [34:0] p_next;
    logic [17:0]        f3;
    logic [16:0]        fp;
    logic [18:0]        fp3;
    logic [32:0]        base_v;
    logic signed [35:0] sum_v;
    logic signed [44:0] num_next;
    logic signed [16:0] band_w;
    logic [31:0]        den_next;
    logic               div_ge;
    logic [7:0]         bucket;
    logic [7:0]         qe;
    logic [63:0]        emask;
    logic [4:0]         ri_inc;
    logic [6:0]         wsum;
    logic [6:0]         tpos;
    logic [6:0]         jpos;
    logic [4:0]         j;
    logic [5:0]         lim;
    logic [32:0]        key_j;
    logic               match;
    logic               out_free;
    logic               room;
    logic               emit_req;
    logic [63:0]        emit_data;
    logic               fin_push;
    logic               do_clear;
    logic [4:0]         bp_inc;

    assign w_eff = (ws_reg > 6'd32) ? 6'd32 : ws_reg;
    assign e_eff = (ec_reg == 5'd0) ? 5'd1 : ((ec_reg > 5'd16) ? 5'd16 : ec_reg);
    assign q_eff = (qb_reg == 4'd0) ? 4'd1 : ((qb_reg > 4'd8) ? 4'd8 : qb_reg);
    assign mx = 8'((9'd1 << q_eff) - 9'd1);
    assign span_v = 7'(kl_reg + {2'b0, e_eff} - 7'd1);

    assign dlt = $signed({smp_reg[15], smp_reg}) - $signed({lks_reg[15], lks_reg});
    assign adlt = dlt[16] ? 17'(-dlt) : dlt;
    assign keep_v = (sidx_reg == 32'd0) || (adlt >= {1'b0, thr_reg});

    assign inb_v = (smp_reg >= fmin_reg) && (smp_reg <= fmax_reg);
    assign fac_a = inb_v ? {1'b0, fsh_reg} : 17'h10000 - {1'b0, fsh_reg};
    assign fac_b = inb_v ? $signed({smp_reg[15], smp_reg}) - $signed({fmin_reg[15], fmin_reg})
                         : $signed({smp_reg[15], smp_reg}) + 17'sd12288;
    assign p_next = $signed({1'b0, fac_a}) * fac_b;

    assign f3 = {2'b0, fsh_reg} + {1'b0, fsh_reg, 1'b0};
    assign fp = {1'b0, fsh_reg} + 17'h10000;
    assign fp3 = {2'b0, fp} + {1'b0, fp, 1'b0};
    assign base_v = neg_reg ? {1'b0, f3, 14'b0} : {1'b0, fp3, 13'b0};
    assign sum_v = inb_reg ? 36'(p_reg) : 36'(p_reg) + $signed({3'b0, base_v});
    assign num_next = $signed({1'b0, mx}) * sum_v;
    assign band_w = $signed({fmax_reg[15], fmax_reg}) - $signed({fmin_reg[15], fmin_reg});
    assign den_next = inb_reg ? {band_w[15:0], 16'b0} : 32'hC000_0000;

    assign div_ge = rem_reg >= dsh_reg;
    assign bucket = zero_reg ? 8'd0 : ((sat_reg || quot_reg > mx) ? mx : quot_reg);

    assign qe = 8'({4'b0, q_eff} * {3'b0, e_eff});
    assign emask = (qe >= 8'd64) ? '1 : (64'd1 << qe) - 64'd1;
    assign ri_inc = {1'b0, ri_reg} + 5'd1;

    assign wsum = {1'b0, w_eff} + {2'b0, e_eff};
    assign tpos = {2'b0, bp_reg} + 7'd1 + {1'b0, cnt_reg};
    assign jpos = (tpos >= {1'b0, w_eff}) ? tpos - {1'b0, w_eff} : tpos;
    assign j = jpos[4:0];
    assign lim = cmd.full ? w_eff - 6'd1 : w_eff - 6'd2;
    assign key_j = wv_reg[j] ? {1'b0, win_reg[j][63:32]} : 33'h1_0000_0000;
    assign match = wv_reg[j] && (win_reg[j][63:32] == cmin_reg[63:32])
                   && (win_reg[j][31:0] != cmin_reg[31:0]);
    assign bp_inc = 5'(({1'b0, bp_reg} + 6'd1 >= w_eff) ? 6'd0 : {1'b0, bp_reg} + 6'd1);

    assign out_free = !out_v_reg || out_ready;
    assign room = !pend_v_reg || out_free;

    always_comb
    begin
        emit_req = 1'b0;
        emit_data = ent_reg;
        unique case (cmd.op)
            OP_EMIT_ENT:
            begin
                emit_req = room;
                emit_data = ent_reg;
            end
            OP_EMIT_MIN:
            begin
                emit_req = room;
                emit_data = cmin_reg;
            end
            OP_TWIN:
            begin
                emit_req = match && room;
                emit_data = win_reg[j];
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign fin_push = (cmd.op == OP_FINAL) && pend_v_reg && out_free;
    assign do_clear = ((cmd.op == OP_LOAD) && first_of_read) || (cmd.op == OP_CLEAR);

    assign stat.keep = keep_v;
    assign stat.ring_full = rfull_reg;
    assign stat.plain = (w_eff == 6'd0);
    assign stat.cond_a = (etot_reg == 32'(wsum - 7'd1)) && mval_reg;
    assign stat.w_one = (w_eff == 6'd1);
    assign stat.less_eq = !mval_reg || (ent_reg[63:32] <= cmin_reg[63:32]);
    assign stat.same_slot = (bp_reg == mp_reg);
    assign stat.ge_e = etot_reg >= 32'(wsum);
    assign stat.ge_e1 = etot_reg >= 32'(wsum - 7'd1);
    assign stat.min_valid = mval_reg;
    assign stat.room = room;
    assign stat.adv = !match || room;
    assign stat.scan_last = (cnt_reg == lim);
    assign stat.div_done = (dcnt_reg == 3'd7);
    assign stat.flush = last_reg && (w_eff != 6'd0) && mval_reg;
    assign stat.last_item = last_reg;
    assign stat.pend_v = pend_v_reg;
    assign stat.fin_ok = !pend_v_reg || out_free;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            ws_reg <= 6'd0;
            ec_reg <= 5'd6;
            qb_reg <= 4'd4;
            kl_reg <= 7'd6;
            thr_reg <= 16'd1433;
            fmin_reg <= -16'sd8192;
            fmax_reg <= 16'sd8192;
            fsh_reg <= 16'd26214;
        end
        else if (write_en)
        begin
            unique case (write_index)
                REG_WINDOW: ws_reg <= write_data[5:0];
                REG_EVENTS: ec_reg <= write_data[4:0];
                REG_QUANT: qb_reg <= write_data[3:0];
                REG_KMER: kl_reg <= write_data[6:0];
                REG_THRESH: thr_reg <= write_data;
                REG_FMIN: fmin_reg <= write_data;
                REG_FMAX: fmax_reg <= write_data;
                REG_FSHARE: fsh_reg <= write_data;
                default: ws_reg <= ws_reg;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.op == OP_WIN)
            win_reg[bp_reg] <= ent_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            lks_reg <= '0;
            sidx_reg <= '0;
            etot_reg <= '0;
            hist_reg <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= '0;
            ri_reg <= '0;
            rfull_reg <= 1'b0;
            wv_reg <= '0;
            widx_reg <= '0;
            cmin_reg <= '1;
            mval_reg <= 1'b0;
            mslot_reg <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
            last_reg <= 1'b0;
            dcnt_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    smp_reg <= sample;
                    tag_reg <= read_id;
                    str_reg <= strand;
                    last_reg <= last_of_read;
                end
                OP_KEEP:
                begin
                    inb_reg <= inb_v;
                    neg_reg <= smp_reg[15];
                    degen_reg <= (fmin_reg == fmax_reg);
                    p_reg <= p_next;
                    if (!keep_v)
                        sidx_reg <= sidx_reg + 32'd1;
                end
                OP_MUL2:
                begin
                    num_reg <= num_next;
                    den_reg <= den_next;
                end
                OP_DIV0:
                begin
                    zero_reg <= num_reg[44] || (inb_reg && degen_reg);
                    sat_reg <= num_reg[43:0] >= {4'b0, den_reg, 8'b0};
                    rem_reg <= num_reg[43:0];
                    dsh_reg <= {5'b0, den_reg, 7'b0};
                    quot_reg <= '0;
                    dcnt_reg <= '0;
                end
                OP_DIV:
                begin
                    if (div_ge)
                        rem_reg <= rem_reg - dsh_reg;
                    quot_reg <= {quot_reg[6:0], div_ge};
                    dsh_reg <= dsh_reg >> 1;
                    dcnt_reg <= dcnt_reg + 3'd1;
                end
                OP_UPD:
                begin
                    lks_reg <= smp_reg;
                    if (etot_reg != '1)
                        etot_reg <= etot_reg + 32'd1;
                    hist_reg <= ((hist_reg << q_eff) | {56'b0, bucket}) & emask;
                    ring_reg[ri_reg] <= sidx_reg;
                    sidx_reg <= sidx_reg + 32'd1;
                    if (ri_inc >= e_eff)
                    begin
                        ri_reg <= '0;
                        rfull_reg <= 1'b1;
                    end
                    else
                    begin
                        ri_reg <= ri_inc[3:0];
                    end
                end
                OP_H1:
                begin
                    h1_reg <= mix_lo(hist_reg[31:0]);
                    ent_reg[31:0] <= ring_reg[ri_reg];
                end
                OP_H2:
                begin
                    ent_reg[63:32] <= mix_hi(h1_reg);
                    bp_reg <= ({1'b0, widx_reg} < w_eff) ? widx_reg : 5'd0;
                    mp_reg <= ({1'b0, mslot_reg} < w_eff) ? mslot_reg : 5'd0;
                end
                OP_WIN:
                begin
                    wv_reg[bp_reg] <= 1'b1;
                    cnt_reg <= '0;
                end
                OP_TWIN:
                begin
                    if (!match || room)
                        cnt_reg <= cnt_reg + 6'd1;
                end
                OP_SETMIN:
                begin
                    cmin_reg <= ent_reg;
                    mval_reg <= 1'b1;
                    mp_reg <= bp_reg;
                end
                OP_RSINIT:
                begin
                    mkey_reg <= 33'h1_0000_0000;
                    cmin_reg <= '1;
                    mval_reg <= 1'b0;
                    cnt_reg <= '0;
                end
                OP_RSCAN:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (mkey_reg >= key_j)
                    begin
                        mkey_reg <= key_j;
                        mval_reg <= wv_reg[j];
                        cmin_reg <= wv_reg[j] ? win_reg[j] : '1;
                        mp_reg <= j;
                    end
                end
                OP_SCAN0:
                begin
                    cnt_reg <= '0;
                end
                OP_WEND:
                begin
                    widx_reg <= bp_inc;
                    mslot_reg <= mp_reg;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase

            if (do_clear)
            begin
                lks_reg <= '0;
                sidx_reg <= '0;
                etot_reg <= '0;
                hist_reg <= '0;
                for (int i = 0; i < RING_DEPTH; i++)
                    ring_reg[i] <= '0;
                ri_reg <= '0;
                rfull_reg <= 1'b0;
                wv_reg <= '0;
                widx_reg <= '0;
                cmin_reg <= '1;
                mval_reg <= 1'b0;
                mslot_reg <= '0;
            end

            // A new result parks in the pending slot; the older one moves to the output.
            if ((emit_req && pend_v_reg) || fin_push)
            begin
                out_v_reg <= 1'b1;
                out_ent_reg <= pend_reg;
                out_tag_reg <= tag_reg;
                out_str_reg <= str_reg;
                out_span_reg <= span_v;
                out_last_reg <= fin_push;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end

            if (emit_req)
            begin
                pend_v_reg <= 1'b1;
                pend_reg <= emit_data;
            end
            else if (fin_push)
            begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_v_reg;
    assign hash_value = out_ent_reg[63:32];
    assign event_position = out_ent_reg[31:0];
    assign read_tag = out_tag_reg;
    assign strand_out = out_str_reg;
    assign span = out_span_reg;
    assign last_of_run = out_last_reg;

endmodule

`default_nettype wire

@@ design/signal_event_minimizer_sketch_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Event minimizer sketch of signal reads. Samples arrive as beats on the samples
// channel; each beat carries one Q3.12 sample, its read identifier and strand, and
// flags that mark the first and last sample of a read. Hash results leave as beats
// on the hashes channel, the last beat caused by a sample flagged by last_of_run.
// Registers are written through write_en, write_index and write_data; the user
// writes them only while idle, which the block does not enforce. One sample is
// handled at a time. A kept event passes through the 8-step restoring divider of
// the quantizer and the two-stage hash. With a window configured, a minimum that
// leaves the window adds a rescan of one entry per cycle (up to 32), and each
// scan for equal hashes checks up to 32 entries, waiting for room per result.
// Results pass through a pending slot and an output register, so a stalled
// receiver holds the block only once both are full. Reset returns the registers
// to their defaults and empties the read state and the window.

module signal_event_minimizer_sketch_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        write_en,
    input  wire logic [2:0]  write_index,
    input  wire logic [15:0] write_data,
    sems_in_if.sink          samples,
    sems_out_if.source       hashes
);
    import sems_pkg::*;

    sems_cmd_t  cmd;
    sems_stat_t stat;

    sems_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sems_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .write_en       (write_en),
        .write_index    (write_index),
        .write_data     (write_data),
        .sample         (samples.sample),
        .read_id        (samples.read_id),
        .strand         (samples.strand),
        .first_of_read  (samples.first_of_read),
        .last_of_read   (samples.last_of_read),
        .out_valid      (hashes.valid),
        .out_ready      (hashes.ready),
        .hash_value     (hashes.hash_value),
        .event_position (hashes.event_position),
        .read_tag       (hashes.read_tag),
        .strand_out     (hashes.strand_out),
        .span           (hashes.span),
        .last_of_run    (hashes.last_of_run),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

`default_nettype wire

@@ test/signal_event_minimizer_sketch_core_tb.sv @@
`timescale 1ns / 1ps

module signal_event_minimizer_sketch_core_tb;
    import sems_pkg::*;

    typedef struct {
        logic signed [15:0] sample;
        logic [31:0]        read_id;
        logic               strand;
        logic               first;
        logic               last;
    } sample_beat_t;

    typedef struct {
        logic [31:0] hash_value;
        logic [31:0] event_position;
        logic [31:0] read_tag;
        logic        strand_out;
        logic [6:0]  span;
        logic        last_of_run;
    } hash_beat_t;

    logic        clk;
    logic        rst_n;
    logic        write_en;
    logic [2:0]  write_index;
    logic [15:0] write_data;

    sems_in_if  samples();
    sems_out_if hashes();

    signal_event_minimizer_sketch_core u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .write_en(write_en),
        .write_index(write_index),
        .write_data(write_data),
        .samples(samples.sink),
        .hashes(hashes.source)
    );

    sample_beat_t sample_q[$];
    hash_beat_t   hash_expect_q[$];
    sample_beat_t on_bus;
    int           err_cnt = 0;
    int           send_idle = 0;
    int           recv_idle = 0;

    // Predictor configuration.
    logic [5:0]         m_win;
    logic [4:0]         m_ev;
    logic [3:0]         m_q;
    logic [6:0]         m_k;
    logic [15:0]        m_thr;
    logic signed [15:0] m_fmin;
    logic signed [15:0] m_fmax;
    logic [15:0]        m_share;

    // Predictor read state.
    logic signed [15:0] last_kept;
    logic [31:0]        sample_idx;
    logic [31:0]        event_cnt;
    logic [63:0]        bucket_hist;
    logic [31:0]        pos_ring[16];
    int unsigned        ring_ptr;
    logic               ring_done;
    logic [63:0]        win_ent[32];
    logic               win_vld[32];
    int unsigned        win_ptr;
    logic [63:0]        min_ent;
    logic               min_vld;
    int unsigned        min_ptr;

    logic [31:0]        cur_tag;
    logic               cur_strand;
    logic [6:0]         cur_span;
    int                 step_hits;

    task automatic clear_read();
        last_kept = 0;
        sample_idx = 0;
        event_cnt = 0;
        bucket_hist = 0;
        for (int i = 0; i < 16; i++)
            pos_ring[i] = 0;
        ring_ptr = 0;
        ring_done = 0;
        for (int i = 0; i < 32; i++)
        begin
            win_ent[i] = '1;
            win_vld[i] = 0;
        end
        win_ptr = 0;
        min_ent = '1;
        min_vld = 0;
        min_ptr = 0;
    endtask

    function automatic logic [31:0] hash32(input logic [31:0] key);
        logic [31:0] h;
        h = ~key + (key << 21);
        h = h ^ (h >> 24);
        h = h + (h << 3) + (h << 8);
        h = h ^ (h >> 14);
        h = h + (h << 2) + (h << 4);
        h = h ^ (h >> 28);
        h = h + (h << 31);
        return h;
    endfunction

    function automatic logic [63:0] bucket_of(input longint s, input int q);
        longint lo;
        longint hi;
        longint f;
        longint mx;
        longint num;
        longint den;
        longint v;
        lo = m_fmin;
        hi = m_fmax;
        f = m_share;
        mx = (longint'(1) << q) - 1;
        if (s >= lo && s <= hi)
        begin
            if (hi == lo)
                return 0;
            num = f * (s - lo) * mx;
            den = 65536 * (hi - lo);
        end
        else
        begin
            num = mx * (((s < 0) ? 2 * f * 24576 : (f + 65536) * 24576)
                        + (65536 - f) * (s + 12288));
            den = longint'(131072) * 24576;
        end
        if (num < 0)
            return 0;
        v = num / den;
        return (v > mx) ? mx : v;
    endfunction

    function automatic logic [32:0] slot_key(input int unsigned j);
        return win_vld[j] ? {1'b0, win_ent[j][63:32]} : 33'h1_0000_0000;
    endfunction

    task automatic push_hash(input logic [63:0] ent);
        hash_beat_t hb;
        if (step_hits >= 64)
            return;
        hb.hash_value = ent[63:32];
        hb.event_position = ent[31:0];
        hb.read_tag = cur_tag;
        hb.strand_out = cur_strand;
        hb.span = cur_span;
        hb.last_of_run = 0;
        hash_expect_q.push_back(hb);
        step_hits++;
    endtask

    task automatic push_ties(input int unsigned from, input int unsigned to);
        for (int unsigned j = from; j < to; j++)
            if (win_vld[j] && win_ent[j][63:32] == min_ent[63:32] &&
                win_ent[j][31:0] != min_ent[31:0])
                push_hash(win_ent[j]);
    endtask

    task automatic track_minimum(input logic [63:0] ent, input int unsigned w,
                                 input int unsigned e);
        int unsigned bp;
        int unsigned mp;
        longint      l;
        logic [32:0] mkey;
        bp = (win_ptr < w) ? win_ptr : 0;
        mp = (min_ptr < w) ? min_ptr : 0;
        l = event_cnt;
        mkey = min_vld ? {1'b0, min_ent[63:32]} : 33'h1_0000_0000;
        win_ent[bp] = ent;
        win_vld[bp] = 1;
        if (l == w + e - 1 && min_vld)
        begin
            push_ties(bp + 1, w);
            push_ties(0, bp);
        end
        if ({1'b0, ent[63:32]} <= mkey)
        begin
            if (l >= w + e && min_vld)
                push_hash(min_ent);
            min_ent = ent;
            min_vld = 1;
            mp = bp;
        end
        else if (bp == mp)
        begin
            if (l >= w + e - 1 && min_vld)
                push_hash(min_ent);
            mkey = 33'h1_0000_0000;
            min_ent = '1;
            min_vld = 0;
            for (int unsigned j = bp + 1; j < w; j++)
                if (mkey >= slot_key(j))
                begin
                    mkey = slot_key(j);
                    min_vld = win_vld[j];
                    min_ent = min_vld ? win_ent[j] : '1;
                    mp = j;
                end
            for (int unsigned j = 0; j <= bp; j++)
                if (mkey >= slot_key(j))
                begin
                    mkey = slot_key(j);
                    min_vld = win_vld[j];
                    min_ent = min_vld ? win_ent[j] : '1;
                    mp = j;
                end
            if (l >= w + e - 1 && min_vld)
            begin
                push_ties(bp + 1, w);
                push_ties(0, bp + 1);
            end
        end
        bp++;
        if (bp >= w)
            bp = 0;
        win_ptr = bp;
        min_ptr = mp;
    endtask

    task automatic predict_hashes(input sample_beat_t it);
        int unsigned w;
        int unsigned e;
        int          q;
        longint      d;
        logic [63:0] emask;
        int unsigned ri;
        logic [63:0] ent;
        w = (m_win > 32) ? 32 : m_win;
        e = (m_ev < 1) ? 1 : ((m_ev > 16) ? 16 : m_ev);
        q = (m_q < 1) ? 1 : ((m_q > 8) ? 8 : m_q);
        step_hits = 0;
        cur_tag = it.read_id;
        cur_strand = it.strand;
        cur_span = 7'(m_k + e - 1);
        if (it.first)
            clear_read();
        d = longint'(it.sample) - longint'(last_kept);
        if (d < 0)
            d = -d;
        if (sample_idx == 0 || d >= m_thr)
        begin
            emask = (q * e >= 64) ? '1 : ((64'd1 << (q * e)) - 1);
            ri = (ring_ptr < 16) ? ring_ptr : 0;
            last_kept = it.sample;
            if (event_cnt != 32'hffff_ffff)
                event_cnt++;
            bucket_hist = ((bucket_hist << q) | bucket_of(it.sample, q)) & emask;
            pos_ring[ri] = sample_idx;
            ri++;
            if (ri >= e)
            begin
                ri = 0;
                ring_done = 1;
            end
            ring_ptr = ri;
            if (ring_done)
            begin
                ent = {hash32(bucket_hist[31:0]), pos_ring[ri]};
                if (w == 0)
                    push_hash(ent);
                else
                    track_minimum(ent, w, e);
            end
        end
        sample_idx++;
        if (it.last)
        begin
            if (w != 0 && min_vld)
                push_hash(min_ent);
            clear_read();
        end
        if (step_hits > 0)
            hash_expect_q[hash_expect_q.size() - 1].last_of_run = 1;
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples.valid <= 0;
            samples.sample <= 0;
            samples.read_id <= 0;
            samples.strand <= 0;
            samples.first_of_read <= 0;
            samples.last_of_read <= 0;
        end
        else
        begin
            if (samples.valid && samples.ready)
                predict_hashes(on_bus);
            if (!samples.valid || samples.ready)
            begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    on_bus = sample_q.pop_front();
                    samples.valid <= 1;
                    samples.sample <= on_bus.sample;
                    samples.read_id <= on_bus.read_id;
                    samples.strand <= on_bus.strand;
                    samples.first_of_read <= on_bus.first;
                    samples.last_of_read <= on_bus.last;
                end
                else
                    samples.valid <= 0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hashes.ready <= 0;
        else
            hashes.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        hash_beat_t exp_b;
        if (rst_n && hashes.valid && hashes.ready)
        begin
            if (hash_expect_q.size() == 0)
            begin
                $display("%0t: unexpected beat hash %h pos %h", $time,
                         hashes.hash_value, hashes.event_position);
                err_cnt++;
            end
            else
            begin
                exp_b = hash_expect_q.pop_front();
                if (hashes.hash_value !== exp_b.hash_value ||
                    hashes.event_position !== exp_b.event_position ||
                    hashes.read_tag !== exp_b.read_tag ||
                    hashes.strand_out !== exp_b.strand_out ||
                    hashes.span !== exp_b.span ||
                    hashes.last_of_run !== exp_b.last_of_run)
                begin
                    $display("%0t: expected %h %h %h %b %0d %b, got %h %h %h %b %0d %b",
                             $time, exp_b.hash_value, exp_b.event_position,
                             exp_b.read_tag, exp_b.strand_out, exp_b.span,
                             exp_b.last_of_run, hashes.hash_value,
                             hashes.event_position, hashes.read_tag, hashes.strand_out,
                             hashes.span, hashes.last_of_run);
                    err_cnt++;
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        write_en <= 1;
        write_index <= idx;
        write_data <= val;
        case (idx)
            REG_WINDOW: m_win = val[5:0];
            REG_EVENTS: m_ev = val[4:0];
            REG_QUANT: m_q = val[3:0];
            REG_KMER: m_k = val[6:0];
            REG_THRESH: m_thr = val;
            REG_FMIN: m_fmin = val;
            REG_FMAX: m_fmax = val;
            default: m_share = val;
        endcase
    endtask

    task automatic configure(input int w, input int e, input int q, input int k,
                             input int thr, input int fmin, input int fmax,
                             input int share);
        reg_write(REG_WINDOW, 16'(w));
        reg_write(REG_EVENTS, 16'(e));
        reg_write(REG_QUANT, 16'(q));
        reg_write(REG_KMER, 16'(k));
        reg_write(REG_THRESH, 16'(thr));
        reg_write(REG_FMIN, 16'(fmin));
        reg_write(REG_FMAX, 16'(fmax));
        reg_write(REG_FSHARE, 16'(share));
        @(posedge clk);
        write_en <= 0;
    endtask

    task automatic queue_sample(input int s, input logic first, input logic last);
        sample_beat_t b;
        b.sample = 16'(s);
        b.read_id = $urandom;
        b.strand = 1'($urandom_range(1));
        b.first = first;
        b.last = last;
        sample_q.push_back(b);
    endtask

    task automatic queue_reads(input int n, input int max_len);
        int          done;
        int          len;
        int          s;
        logic [31:0] id;
        logic        st;
        sample_beat_t b;
        done = 0;
        while (done < n)
        begin
            len = $urandom_range(1, max_len);
            id = $urandom;
            st = 1'($urandom_range(1));
            s = $urandom_range(0, 16000) - 8000;
            for (int i = 0; i < len && done < n; i++)
            begin
                if ($urandom_range(9) == 0)
                    s = $urandom_range(0, 65535) - 32768;
                else
                    s = s + $urandom_range(0, 6000) - 3000;
                if (s > 32767)
                    s = 32767;
                if (s < -32768)
                    s = -32768;
                b.sample = 16'(s);
                b.read_id = ($urandom_range(19) == 0) ? $urandom : id;
                b.strand = ($urandom_range(19) == 0) ? !st : st;
                b.first = (i == 0) || ($urandom_range(49) == 0);
                b.last = ((i == len - 1) && $urandom_range(3) != 0) ||
                         ($urandom_range(49) == 0);
                sample_q.push_back(b);
                done++;
            end
        end
    endtask

    task automatic drain();
        wait (sample_q.size() == 0 && !samples.valid && hash_expect_q.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        write_en = 0;
        write_index = 0;
        write_data = 0;
        m_win = 6'd0;
        m_ev = 5'd6;
        m_q = 4'd4;
        m_k = 7'd6;
        m_thr = 16'd1433;
        m_fmin = -16'sd8192;
        m_fmax = 16'sd8192;
        m_share = 16'd26214;
        clear_read();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        send_idle = 18;
        recv_idle = 52;
        configure(0, 0, 0, 0, 0, -8192, 8192, 0);
        queue_sample(-32768, 1, 0);
        queue_sample(32767, 0, 0);
        queue_sample(0, 0, 0);
        queue_sample(-1, 0, 0);
        queue_sample(8192, 0, 0);
        queue_sample(-8192, 0, 1);
        queue_sample(100, 1, 1);
        drain();

        configure(1, 16, 8, 64, 65535, 0, 0, 65535);
        queue_sample(0, 1, 0);
        queue_sample(-32768, 0, 0);
        queue_sample(32767, 0, 0);
        queue_sample(0, 0, 1);
        drain();

        configure(63, 31, 15, 127, 0, 8192, -8192, 65535);
        for (int i = 0; i < 10; i++)
            queue_sample($urandom_range(0, 65535) - 32768, i == 0, i == 9);
        drain();

        configure(0, 3, 4, 6, 500, -8192, 8192, 26214);
        queue_reads(30, 20);
        drain();
        configure(4, 2, 2, 9, 300, $urandom_range(0, 8000) - 12000,
                  $urandom_range(0, 12000), $urandom);
        queue_reads(30, 30);
        drain();

        send_idle = 52;
        recv_idle = 18;
        configure(32, 1, 3, 1, 0, -8192, 8192, 26214);
        queue_reads(30, 60);
        drain();
        configure(5, 6, 4, 6, 1433, -8192, 8192, 26214);
        queue_reads(30, 40);
        drain();

        send_idle = 0;
        recv_idle = 0;
        configure(10, 4, 8, 20, 2000, $urandom_range(0, 30000) - 32768,
                  $urandom_range(0, 32767), $urandom);
        queue_reads(30, 40);
        drain();
        configure(2, 16, 4, 64, 800, -4096, 4096, 65535);
        queue_reads(30, 50);
        drain();

        if (err_cnt == 0)
            $display("signal_event_minimizer_sketch_core_tb: clean");
        else
            $display("signal_event_minimizer_sketch_core_tb: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("signal_event_minimizer_sketch_core_tb: errors");
        $finish;
    end

endmodule

@@ signal_event_minimizer_sketch_core.f @@
design/sems_pkg.sv
design/sems_in_if.sv
design/sems_out_if.sv
design/sems_ctrl.sv
design/sems_dp.sv
design/signal_event_minimizer_sketch_core.sv
test/signal_event_minimizer_sketch_core_tb.sv
